[hdl/ljpcc_pkg.sv]
// Shared constants and types of the Lennard-Jones pair coefficient combiner.
// No dependencies; imported by ljpcc_isqrt and the core, not by ljpcc_mul.
package ljpcc_pkg;

   // Square root: a 64-bit radicand gives a 32-bit root, two digits per stage.
   localparam int RAD_W                = 64;
   localparam int ROOT_W               = 32;
   localparam int REM_W                = 34;
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

   // Each product is built in two stages: partial products, then their sum.
   localparam int MUL_STAGES  = 2;
   localparam int MUL_COUNT   = 5;
   localparam int PIPE_STAGES = 1 + SQRT_STAGES + MUL_COUNT * MUL_STAGES;

   // Configuration register indexes.
   localparam logic REG_GEOMETRIC_SIGMA = 1'b0;
   localparam logic REG_FOUR_EPSILON    = 1'b1;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

endpackage

[hdl/ljpcc_mul.sv]
// Two-stage unsigned multiplier built from 32x32 partial products.
// Depends on nothing but its parameters; operands are at most 64 bits wide.
module ljpcc_mul #(
   parameter int WA = 32,
   parameter int WB = 32,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WA-1:0]    a,
   input  logic [WB-1:0]    b,
   input  logic [SW-1:0]    side_in,
   output logic [WA+WB-1:0] prod,
   output logic [SW-1:0]    side_out
);

   logic [63:0]       a_x, b_x;
   logic [63:0]       pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [SW-1:0]     side1_ff, side2_ff;
   logic [127:0]      sum;
   logic [WA+WB-1:0]  prod_ff, prod_in;

   assign a_x = 64'(a);
   assign b_x = 64'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= a_x[31:0]  * b_x[31:0];
         pp_lh_ff <= a_x[31:0]  * b_x[63:32];
         pp_hl_ff <= a_x[63:32] * b_x[31:0];
         pp_hh_ff <= a_x[63:32] * b_x[63:32];
         side1_ff <= side_in;
      end
   end

   always_comb begin
      sum = 128'(pp_ll_ff) + (128'(pp_lh_ff) << 32) + (128'(pp_hl_ff) << 32)
            + (128'(pp_hh_ff) << 64);
      prod_in = sum[WA+WB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         side2_ff <= side1_ff;
      end
   end

   assign prod     = prod_ff;
   assign side_out = side2_ff;

endmodule

[hdl/ljpcc_isqrt.sv]
// Pipelined integer square root of two radicands side by side, two root digits
// per stage. Depends on ljpcc_pkg for widths and the per-digit state type.
module ljpcc_isqrt #(
   parameter int SW = 1
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [ljpcc_pkg::RAD_W-1:0]  rad_a,
   input  logic [ljpcc_pkg::RAD_W-1:0]  rad_b,
   input  logic [SW-1:0]            side_in,
   output logic [ljpcc_pkg::ROOT_W-1:0] root_a,
   output logic [ljpcc_pkg::ROOT_W-1:0] root_b,
   output logic [SW-1:0]            side_out
);
   import ljpcc_pkg::*;

   // One restoring digit: bring down two radicand bits, try (root*4 + 1).
   function automatic sqrt_state_type sqrt_iter(input sqrt_state_type s);
      logic [REM_W+1:0] rx;
      logic [REM_W+1:0] trial;
      sqrt_state_type   r;
      rx    = {s.rem, s.rad[RAD_W-1:RAD_W-2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rx >= trial) begin
         r.rem  = REM_W'(rx - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rx[REM_W-1:0];
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   sqrt_state_type st_a_ff [SQRT_STAGES];
   sqrt_state_type st_b_ff [SQRT_STAGES];
   logic [SW-1:0]  side_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      sqrt_state_type a_src, b_src, a_in, b_in;
      logic [SW-1:0]  side_src;

      if (g == 0) begin : g_first
         assign a_src    = '{rad: rad_a, rem: '0, root: '0};
         assign b_src    = '{rad: rad_b, rem: '0, root: '0};
         assign side_src = side_in;
      end else begin : g_next
         assign a_src    = st_a_ff[g-1];
         assign b_src    = st_b_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      always_comb begin
         a_in = a_src;
         b_in = b_src;
         for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
            a_in = sqrt_iter(a_in);
            b_in = sqrt_iter(b_in);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_a_ff[g] <= a_in;
            st_b_ff[g] <= b_in;
            side_ff[g] <= side_src;
         end
      end
   end

   assign root_a   = st_a_ff[SQRT_STAGES-1].root;
   assign root_b   = st_b_ff[SQRT_STAGES-1].root;
   assign side_out = side_ff[SQRT_STAGES-1];

endmodule

[hdl/lj_pair_coefficient_combine_core.sv]
// Stages from an input transfer to its result transfer: one input stage,
// 16 square-root stages, five 2-stage multipliers, output register.
// Throughput: one pair per cycle unless the two-entry output buffer is full; the whole
// pipeline advances together and keeps moving while one result waits.
// Reset (synchronous, active high) clears all valid bits and both mode registers.
// Depends on ljpcc_pkg, ljpcc_isqrt and ljpcc_mul.
module lj_pair_coefficient_combine_core #(
   parameter int MAX_TYPES = 64
) (
   input  logic         clock,
   input  logic         reset,
   // Input item, lowest bit first: type_first(6), type_second(6),
   // epsilon_first(32), sigma_first(32), epsilon_second(32), sigma_second(32), pad(4).
   input  logic [143:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Result item, lowest bit first: coeff_repulsive(64), coeff_attractive(64),
   // pair_slot(12), pad(4).
   output logic [143:0] rsp_tdata,
   // Result flag: saturated(1).
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic         csr_wdata
);
   import ljpcc_pkg::*;

   typedef struct packed {
      logic [63:0] coeff_repulsive;
      logic [63:0] coeff_attractive;
      logic [11:0] pair_slot;
      logic        saturated;
   } rsp_type;

   // Types at or beyond the table are clamped to the last row for the slot.
   localparam logic [6:0] TYPE_LIM = 7'((MAX_TYPES > 64) ? 64 : MAX_TYPES);

   // Mode registers. Writes must arrive only while the pipeline is empty; unchecked.
   logic geo_ff, four_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff  <= 1'b0;
         four_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_GEOMETRIC_SIGMA: geo_ff  <= csr_wdata;
            REG_FOUR_EPSILON:    four_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   // Pipeline control. All stages load together whenever the output buffer
   // has its spare entry free, so no item is dropped or duplicated.
   logic                   en;
   logic [PIPE_STAGES-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PIPE_STAGES-2:0], req_tvalid};
      end
   end

   assign req_tready = en;

   // Input stage: the two 32x32 products under the square roots, the
   // arithmetic mean of sigma and the packed triangle slot.
   logic [5:0]  t1, t2, t1_c, t2_c, row, col;
   logic [31:0] e1, e2, s1, s2;
   logic [11:0] slot_in;
   logic [63:0] eps_prod_ff, sig_prod_ff;
   logic [31:0] amean_ff, amean_in;
   logic [11:0] slot_ff;
   logic [32:0] sig_sum;

   assign t1 = req_tdata[5:0];
   assign t2 = req_tdata[11:6];
   assign e1 = req_tdata[43:12];
   assign s1 = req_tdata[75:44];
   assign e2 = req_tdata[107:76];
   assign s2 = req_tdata[139:108];

   always_comb begin
      t1_c     = ({1'b0, t1} >= TYPE_LIM) ? 6'(TYPE_LIM - 7'd1) : t1;
      t2_c     = ({1'b0, t2} >= TYPE_LIM) ? 6'(TYPE_LIM - 7'd1) : t2;
      row      = (t1_c >= t2_c) ? t1_c : t2_c;
      col      = (t1_c >= t2_c) ? t2_c : t1_c;
      slot_in  = 12'(({6'b0, row} * ({6'b0, row} + 12'd1)) >> 1) + {6'b0, col};
      sig_sum  = {1'b0, s1} + {1'b0, s2};
      amean_in = sig_sum[32:1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eps_prod_ff <= e1 * e2;
         sig_prod_ff <= s1 * s2;
         amean_ff    <= amean_in;
         slot_ff     <= slot_in;
      end
   end

   // Square roots of both products; the mean and the slot ride alongside.
   logic [31:0] e_root, s_root, amean_q;
   logic [11:0] slot_q;

   ljpcc_isqrt #(.SW(44)) u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad_a    (eps_prod_ff),
      .rad_b    (sig_prod_ff),
      .side_in  ({amean_ff, slot_ff}),
      .root_a   (e_root),
      .root_b   (s_root),
      .side_out ({amean_q, slot_q})
   );

   // Combined sigma, then its powers in Q.28.
   logic [31:0] s_comb;
   logic [63:0] prod1;
   logic [31:0] e_m1;
   logic [11:0] slot_m1;

   assign s_comb = geo_ff ? s_root : amean_q;

   ljpcc_mul #(.WA(32), .WB(32), .SW(44)) u_mul_sq (
      .clock (clock), .en (en), .a (s_comb), .b (s_comb),
      .side_in ({e_root, slot_q}), .prod (prod1), .side_out ({e_m1, slot_m1})
   );

   logic [35:0] sq1, sq_m2;
   logic [71:0] prod2;
   logic [31:0] e_m2;
   logic [11:0] slot_m2;

   assign sq1 = prod1[63:28];

   ljpcc_mul #(.WA(36), .WB(36), .SW(80)) u_mul_s4 (
      .clock (clock), .en (en), .a (sq1), .b (sq1),
      .side_in ({sq1, e_m1, slot_m1}), .prod (prod2), .side_out ({sq_m2, e_m2, slot_m2})
   );

   logic [43:0] s4;
   logic [79:0] prod3;
   logic [31:0] e_m3;
   logic [11:0] slot_m3;

   assign s4 = prod2[71:28];

   ljpcc_mul #(.WA(44), .WB(36), .SW(44)) u_mul_s6 (
      .clock (clock), .en (en), .a (s4), .b (sq_m2),
      .side_in ({e_m2, slot_m2}), .prod (prod3), .side_out ({e_m3, slot_m3})
   );

   // One product ex*s6 serves both the B coefficient and the partial A term.
   logic [51:0] s6, s6_m4;
   logic [33:0] ex;
   logic [85:0] prod4;
   logic [11:0] slot_m4;

   assign s6 = prod3[79:28];
   assign ex = four_ff ? {e_m3, 2'b00} : {2'b00, e_m3};

   ljpcc_mul #(.WA(34), .WB(52), .SW(64)) u_mul_eps (
      .clock (clock), .en (en), .a (ex), .b (s6),
      .side_in ({s6, slot_m3}), .prod (prod4), .side_out ({s6_m4, slot_m4})
   );

   // B never exceeds 43 bits; in the doubled form it keeps one more fraction bit.
   logic [61:0]  p_term;
   logic [42:0]  b_coef, b_m5;
   logic [113:0] prod5;
   logic [11:0]  slot_m5;

   assign p_term = prod4[85:24];
   assign b_coef = four_ff ? 43'(prod4[85:44]) : prod4[85:43];

   ljpcc_mul #(.WA(62), .WB(52), .SW(55)) u_mul_rep (
      .clock (clock), .en (en), .a (p_term), .b (s6_m4),
      .side_in ({b_coef, slot_m4}), .prod (prod5), .side_out ({b_m5, slot_m5})
   );

   // A is clipped to all ones when the product reaches 2^112.
   rsp_type up_data;
   logic    up_v, a_sat;

   assign up_v  = v_ff[PIPE_STAGES-1];
   assign a_sat = |prod5[113:112];

   always_comb begin
      up_data.coeff_repulsive  = a_sat ? '1 : prod5[111:48];
      up_data.coeff_attractive = 64'(b_m5);
      up_data.pair_slot        = slot_m5;
      up_data.saturated        = a_sat;
   end

   // Output register plus one spare entry. The spare fills only when a result
   // arrives while the output register is held; the pipeline then stops.
   rsp_type out_ff, out_in, sk_ff, sk_in;
   logic    out_v_ff, out_v_in, sk_v_ff, sk_v_in;
   logic    pop, push;

   assign en   = !sk_v_ff;
   assign pop  = out_v_ff && rsp_tready;
   assign push = up_v && en;

   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      sk_in    = sk_ff;
      sk_v_in  = sk_v_ff;
      if (!out_v_ff || pop) begin
         out_v_in = sk_v_ff || push;
         out_in   = sk_v_ff ? sk_ff : up_data;
         sk_v_in  = 1'b0;
      end else if (push) begin
         sk_v_in = 1'b1;
         sk_in   = up_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sk_ff  <= sk_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0000, out_ff.pair_slot, out_ff.coeff_attractive,
                        out_ff.coeff_repulsive};
   assign rsp_tuser  = out_ff.saturated;

   // The spare entry is only ever occupied behind a held output register.
   a_spare_behind_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("spare entry valid while output register empty");

   // A result leaving the pipeline while the output is held must be parked.
   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (push && out_v_ff && !rsp_tready) |=> sk_v_ff)
      else $error("result lost while output stalled");

   // The saturation flag only accompanies a fully clipped A coefficient.
   a_sat_means_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (&rsp_tdata[63:0]))
      else $error("saturated flag without clipped coefficient");

endmodule
